/* sv/rf_power_swr_gain_meter_defines.svh */
// ----------------------------------------------------------------------------
// RF power meter assertion macros
// Assertion forms for the meter's core, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef RF_POWER_SWR_GAIN_METER_DEFINES_SVH
`define RF_POWER_SWR_GAIN_METER_DEFINES_SVH

// property holds on every edge out of reset
`define RPSG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition on one edge implies a condition on the next edge
`define RPSG_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

/* sv/rpsg_pkg.sv */
// ----------------------------------------------------------------------------
// RF power meter package
// Shared constants, register codes and configuration type.
// ----------------------------------------------------------------------------
package rpsg_pkg;

	localparam int POWER_WIDTH_DEF = 20;

	localparam logic [1:0] REG_ENABLED      = 2'd0;
	localparam logic [1:0] REG_DECAY_ALPHA  = 2'd1;
	localparam logic [1:0] REG_INPUT_FLOOR  = 2'd2;
	localparam logic [1:0] REG_OUTPUT_FLOOR = 2'd3;

	localparam logic [7:0]  ALPHA_RST     = 8'd51;
	localparam logic [19:0] IN_FLOOR_RST  = 20'd6;
	localparam logic [19:0] OUT_FLOOR_RST = 20'd64;

	localparam logic [31:0] GAIN_K = 32'd3156528;

	typedef struct packed {
		logic        enabled;
		logic [7:0]  decay_alpha;
		logic [19:0] input_floor;
		logic [19:0] output_floor;
	} cfg_t;

endpackage

/* sv/rpsg_regs.sv */
// ----------------------------------------------------------------------------
// RF power meter register file
// Configuration registers behind a 32-bit APB-style port.
// ----------------------------------------------------------------------------
module rpsg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output rpsg_pkg::cfg_t     cfg
);

	rpsg_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled      <= 1'b0;
			cfg_q.decay_alpha  <= rpsg_pkg::ALPHA_RST;
			cfg_q.input_floor  <= rpsg_pkg::IN_FLOOR_RST;
			cfg_q.output_floor <= rpsg_pkg::OUT_FLOOR_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				rpsg_pkg::REG_ENABLED:      cfg_q.enabled      <= pwdata[0];
				rpsg_pkg::REG_DECAY_ALPHA:  cfg_q.decay_alpha  <= pwdata[7:0];
				rpsg_pkg::REG_INPUT_FLOOR:  cfg_q.input_floor  <= pwdata[19:0];
				rpsg_pkg::REG_OUTPUT_FLOOR: cfg_q.output_floor <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rpsg_pkg::REG_ENABLED:      prdata = {31'd0, cfg_q.enabled};
			rpsg_pkg::REG_DECAY_ALPHA:  prdata = {24'd0, cfg_q.decay_alpha};
			rpsg_pkg::REG_INPUT_FLOOR:  prdata = {12'd0, cfg_q.input_floor};
			rpsg_pkg::REG_OUTPUT_FLOOR: prdata = {12'd0, cfg_q.output_floor};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

/* sv/rpsg_core.sv */
// ----------------------------------------------------------------------------
// RF power meter sequencer
// Averages, SWR and gain computed over many cycles on one shared multiplier,
// one shared divide step and one root step.
// ----------------------------------------------------------------------------
`include "rf_power_swr_gain_meter_defines.svh"

module rpsg_core #(
	parameter int PW = rpsg_pkg::POWER_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rpsg_pkg::cfg_t      cfg,
	input  logic                start,
	output logic                ready,
	input  logic [PW-1:0]       input_forward,
	input  logic [PW-1:0]       output_forward,
	input  logic [PW-1:0]       output_reverse,
	output logic                res_valid,
	input  logic                out_free,
	output logic                updated,
	output logic [PW-1:0]       input_average,
	output logic [PW-1:0]       output_average,
	output logic [PW-1:0]       reverse_average,
	output logic [15:0]         swr_ratio,
	output logic signed [10:0]  gain_db
);

	localparam int DW = (PW > 17) ? PW : 17;
	localparam int NW = $clog2(PW);
	localparam int LW = NW + 16;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_AMUL = 4'd1;
	localparam logic [3:0] S_AUPD = 4'd2;
	localparam logic [3:0] S_SWR  = 4'd3;
	localparam logic [3:0] S_DIV1 = 4'd4;
	localparam logic [3:0] S_SQRT = 4'd5;
	localparam logic [3:0] S_DIV2 = 4'd6;
	localparam logic [3:0] S_GAIN = 4'd7;
	localparam logic [3:0] S_NORM = 4'd8;
	localparam logic [3:0] S_SQM  = 4'd9;
	localparam logic [3:0] S_SQN  = 4'd10;
	localparam logic [3:0] S_GMUL = 4'd11;
	localparam logic [3:0] S_GRND = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	localparam logic [1:0] AV_IN  = 2'd0;
	localparam logic [1:0] AV_OUT = 2'd1;
	localparam logic [1:0] AV_REV = 2'd2;

	logic [3:0]         state_q;
	logic [PW-1:0]      inf_q, outf_q, outr_q;
	logic               fast_in_q, fast_out_q;
	logic [PW-1:0]      in_avg_q, out_avg_q, rev_avg_q;
	logic [1:0]         sel_q;
	logic [5:0]         cnt_q;
	logic [DW-1:0]      rem_q, den_q;
	logic [24:0]        numsh_q;
	logic [31:0]        quo_q;
	logic [31:0]        sv_q, sres_q, sbit_q;
	logic [PW-1:0]      z_q;
	logic [NW-1:0]      n_q;
	logic [30:0]        y_q;
	logic [15:0]        frac_q;
	logic               lsel_q;
	logic [LW-1:0]      logo_q;
	logic [LW-1:0]      absd_q;
	logic               neg_q;
	logic [63:0]        prod_q;
	logic               upd_q;
	logic [15:0]        swr_q;
	logic signed [10:0] gain_q;

	logic [31:0]        mul_a, mul_b;
	logic [PW-1:0]      avg_cur, s_cur, d_cur, step, nv;
	logic               fast_cur;
	logic [PW+8:0]      step_full;
	logic [DW:0]        dv_t;
	logic               dv_ge;
	logic [DW-1:0]      rem_nx;
	logic [31:0]        quo_nx;
	logic [32:0]        sq_sum;
	logic               sq_ge;
	logic [31:0]        sres_nx;
	logic [15:0]        rho;
	logic [PW+30:0]     zz;
	logic [31:0]        sq_t;
	logic [15:0]        frac_nx;
	logic [LW-1:0]      logv;
	logic [LW:0]        dlog;
	logic [63:0]        rnd;
	logic [31:0]        mag;
	logic               active;

	assign ready           = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_DONE);
	assign updated         = upd_q;
	assign input_average   = in_avg_q;
	assign output_average  = out_avg_q;
	assign reverse_average = rev_avg_q;
	assign swr_ratio       = swr_q;
	assign gain_db         = gain_q;

	assign active = cfg.enabled && ((input_forward != '0) || (in_avg_q != '0) ||
		(out_avg_q != '0) || (rev_avg_q != '0));

	always_comb begin
		case (sel_q)
			AV_IN:   begin avg_cur = in_avg_q;  s_cur = inf_q;  fast_cur = fast_in_q;  end
			AV_OUT:  begin avg_cur = out_avg_q; s_cur = outf_q; fast_cur = fast_out_q; end
			default: begin avg_cur = rev_avg_q; s_cur = outr_q; fast_cur = fast_out_q; end
		endcase
		d_cur     = (s_cur >= avg_cur) ? (s_cur - avg_cur) : (avg_cur - s_cur);
		step_full = prod_q[PW+8:0] + (PW+9)'(255);
		step      = step_full[PW+7:8];
		if (fast_cur)
			nv = s_cur;
		else if (s_cur >= avg_cur)
			nv = avg_cur + step;
		else
			nv = avg_cur - step;
	end

	always_comb begin
		case (state_q)
			S_AMUL:  begin mul_a = {24'd0, cfg.decay_alpha}; mul_b = 32'(d_cur); end
			S_SQM:   begin mul_a = {1'b0, y_q};              mul_b = {1'b0, y_q}; end
			S_GMUL:  begin mul_a = 32'(absd_q);              mul_b = rpsg_pkg::GAIN_K; end
			default: begin mul_a = 32'd0;                    mul_b = 32'd0; end
		endcase
	end

	assign dv_t   = {rem_q, numsh_q[24]};
	assign dv_ge  = dv_t >= {1'b0, den_q};
	assign rem_nx = dv_ge ? DW'(dv_t - {1'b0, den_q}) : DW'(dv_t);
	assign quo_nx = {quo_q[30:0], dv_ge};

	assign sq_sum  = {1'b0, sres_q} + {1'b0, sbit_q};
	assign sq_ge   = {1'b0, sv_q} >= sq_sum;
	assign sres_nx = sq_ge ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
	assign rho     = sres_nx[15:0];

	assign zz      = {z_q, 31'd0};
	assign sq_t    = prod_q[61:30];
	assign frac_nx = {frac_q[14:0], sq_t[31]};
	assign logv    = {n_q, frac_nx};
	assign dlog    = {1'b0, logo_q} - {1'b0, logv};
	assign rnd     = prod_q + 64'h0000_0000_8000_0000;
	assign mag     = rnd[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_avg_q  <= '0;
			out_avg_q <= '0;
			rev_avg_q <= '0;
			upd_q     <= 1'b0;
			swr_q     <= '0;
			gain_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						inf_q      <= input_forward;
						outf_q     <= output_forward;
						outr_q     <= output_reverse;
						fast_in_q  <= input_forward > in_avg_q;
						fast_out_q <= output_forward > out_avg_q;
						sel_q      <= AV_IN;
						swr_q      <= '0;
						gain_q     <= '0;
						upd_q      <= active;
						state_q    <= active ? S_AMUL : S_DONE;
					end
				end
				S_AMUL: state_q <= S_AUPD;
				S_AUPD: begin
					case (sel_q)
						AV_IN: begin
							in_avg_q <= (33'(nv) < 33'(cfg.input_floor)) ? '0 : nv;
							sel_q    <= AV_OUT;
							state_q  <= S_AMUL;
						end
						AV_OUT: begin
							out_avg_q <= (33'(nv) < 33'(cfg.output_floor)) ? '0 : nv;
							sel_q     <= AV_REV;
							state_q   <= S_AMUL;
						end
						default: begin
							rev_avg_q <= nv;
							state_q   <= S_SWR;
						end
					endcase
				end
				S_SWR: begin
					rem_q   <= DW'(rev_avg_q);
					den_q   <= DW'(out_avg_q);
					numsh_q <= '0;
					quo_q   <= '0;
					cnt_q   <= '0;
					if (outf_q == '0)
						state_q <= S_GAIN;
					else if ((out_avg_q == '0) || (rev_avg_q >= out_avg_q)) begin
						swr_q   <= 16'hFFFF;
						state_q <= S_GAIN;
					end else
						state_q <= S_DIV1;
				end
				S_DIV1: begin
					rem_q   <= rem_nx;
					numsh_q <= {numsh_q[23:0], 1'b0};
					quo_q   <= quo_nx;
					cnt_q   <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						sv_q    <= quo_nx;
						sres_q  <= '0;
						sbit_q  <= 32'h4000_0000;
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_ge)
						sv_q <= sv_q - sq_sum[31:0];
					sres_q <= sres_nx;
					sbit_q <= sbit_q >> 2;
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) begin
						rem_q   <= '0;
						den_q   <= DW'(17'd65536 - {1'b0, rho});
						numsh_q <= {17'd65536 + {1'b0, rho}, 8'd0};
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					rem_q   <= rem_nx;
					numsh_q <= {numsh_q[23:0], 1'b0};
					quo_q   <= quo_nx;
					cnt_q   <= cnt_q + 6'd1;
					if (cnt_q == 6'd24) begin
						swr_q   <= (quo_nx[31:16] != '0) ? 16'hFFFF : quo_nx[15:0];
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					z_q    <= out_avg_q;
					n_q    <= NW'(PW - 1);
					lsel_q <= 1'b0;
					if ((inf_q == '0) || (outf_q == '0) ||
						((out_avg_q == '0) && (in_avg_q == '0)))
						state_q <= S_DONE;
					else if (out_avg_q == '0) begin
						gain_q  <= -11'sd1024;
						state_q <= S_DONE;
					end else if (in_avg_q == '0) begin
						gain_q  <= 11'sd1023;
						state_q <= S_DONE;
					end else
						state_q <= S_NORM;
				end
				S_NORM: begin
					if (z_q[PW-1]) begin
						y_q     <= zz[PW+30 -: 31];
						frac_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_SQM;
					end else begin
						z_q <= {z_q[PW-2:0], 1'b0};
						n_q <= n_q - NW'(1);
					end
				end
				S_SQM: state_q <= S_SQN;
				S_SQN: begin
					y_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
					frac_q <= frac_nx;
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) begin
						if (!lsel_q) begin
							logo_q  <= logv;
							lsel_q  <= 1'b1;
							z_q     <= in_avg_q;
							n_q     <= NW'(PW - 1);
							state_q <= S_NORM;
						end else begin
							neg_q   <= dlog[LW];
							absd_q  <= dlog[LW] ? LW'(-dlog) : dlog[LW-1:0];
							state_q <= S_GMUL;
						end
					end else
						state_q <= S_SQM;
				end
				S_GMUL: state_q <= S_GRND;
				S_GRND: begin
					if (!neg_q)
						gain_q <= (mag > 32'd1023) ? 11'sd1023 : $signed(mag[10:0]);
					else
						gain_q <= (mag > 32'd1024) ? -11'sd1024 : -$signed(mag[10:0]);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	`RPSG_ASSERT_NEXT(a_done_hold, (state_q == S_DONE) && !out_free, state_q == S_DONE, "result dropped before the output stage was free")
	`RPSG_ASSERT(a_div_rem, (state_q != S_DIV1 && state_q != S_DIV2) || (rem_q < den_q), "divider remainder not below divisor")
	`RPSG_ASSERT(a_idle_zero, (state_q != S_DONE) || upd_q || ((swr_q == 16'd0) && (gain_q == 11'sd0)), "idle sample reported nonzero SWR or gain")
	`RPSG_ASSERT(a_norm_nz, (state_q != S_NORM) || (z_q != '0), "log normalisation on a zero average")

endmodule

/* sv/rf_power_swr_gain_meter.sv */
// ----------------------------------------------------------------------------
// RF power, SWR and gain meter
// Smoothed forward and reflected power with SWR and amplifier gain per sample.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         one power sample (input fwd, output fwd, output rev)
//  m_*       out        averages, SWR Q8.8, gain 1/16 dB; tuser = updated
//  APB       in/out     enabled, decay_alpha, input_floor, output_floor
//
//  An updated sample may use the one-bit-per-cycle divider (32 and 25
//  steps), the 16-step root and two logarithms, each normalised by
//  shifting and refined by squaring on the shared multiplier; an idle
//  or disabled sample uses none of these.
//  s_tready is high only while the sequencer is idle; a finished result
//  waits in the output register while the next sample is taken.
//  Reset clears the averages and restores the register defaults.
// ----------------------------------------------------------------------------
module rf_power_swr_gain_meter #(
	parameter int POWER_WIDTH = rpsg_pkg::POWER_WIDTH_DEF,
	localparam int IW = ((3 * POWER_WIDTH + 7) / 8) * 8,
	localparam int OW = ((3 * POWER_WIDTH + 27 + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          s_tvalid,
	output logic          s_tready,
	// input_forward, output_forward, output_reverse
	input  logic [IW-1:0] s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// input_average, output_average, reverse_average, swr_ratio, gain_db
	output logic [OW-1:0] m_tdata,
	// updated
	output logic          m_tuser
);

	localparam int PW = POWER_WIDTH;

	rpsg_pkg::cfg_t     cfg;
	logic               core_ready, res_valid, out_free;
	logic               updated;
	logic [PW-1:0]      in_avg, out_avg, rev_avg;
	logic [15:0]        swr_ratio;
	logic signed [10:0] gain_db;
	logic               m_tvalid_q;
	logic [OW-1:0]      m_tdata_q;
	logic               m_tuser_q;

	rpsg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rpsg_core #(.PW(PW)) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.start           (s_tvalid),
		.ready           (core_ready),
		.input_forward   (s_tdata[PW-1:0]),
		.output_forward  (s_tdata[2*PW-1:PW]),
		.output_reverse  (s_tdata[3*PW-1:2*PW]),
		.res_valid       (res_valid),
		.out_free        (out_free),
		.updated         (updated),
		.input_average   (in_avg),
		.output_average  (out_avg),
		.reverse_average (rev_avg),
		.swr_ratio       (swr_ratio),
		.gain_db         (gain_db)
	);

	assign s_tready = core_ready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_free)
			m_tvalid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_tdata_q <= OW'({gain_db, swr_ratio, rev_avg, out_avg, in_avg});
			m_tuser_q <= updated;
		end
	end

endmodule

/* bench/rf_power_swr_gain_meter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RF power, SWR and gain meter testbench
// Drives power samples through the stream port under several register
// settings and idling patterns, predicts the averaged result, SWR and gain
// of most samples in bit-true integer arithmetic, takes the rest from a
// table and checks every result in order.
module rf_power_swr_gain_meter_tb;

	localparam int PW = 20;
	localparam logic [PW-1:0] PMAX = '1;
	localparam int N_PHASE = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic          updated;
		logic [PW-1:0] in_avg;
		logic [PW-1:0] out_avg;
		logic [PW-1:0] rev_avg;
		logic [15:0]   swr;
		logic [10:0]   gain;
	} meter_t;

	typedef struct {
		logic          en;
		logic [PW-1:0] fwd_in;
		logic [PW-1:0] fwd_out;
		logic [PW-1:0] rev_out;
		logic          typed;
		meter_t        res;
	} row_t;

	typedef struct {
		logic          en;
		logic [7:0]    alpha;
		logic [PW-1:0] in_floor;
		logic [PW-1:0] out_floor;
		int            src_idle;
		int            snk_stall;
	} phase_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic s_tvalid, s_tready;
	// input_forward, output_forward, output_reverse
	logic [63:0] s_tdata;
	logic m_tvalid, m_tready;
	// input_average, output_average, reverse_average, swr_ratio, gain_db
	logic [87:0] m_tdata;
	// updated
	logic m_tuser;

	logic          cur_en;
	logic [7:0]    cur_alpha;
	logic [PW-1:0] cur_in_floor, cur_out_floor;
	logic [PW-1:0] avg_in, avg_out, avg_rev;

	meter_t pending_results[$];
	int src_idle, snk_stall;
	int n_fail;
	int cycles;

	rf_power_swr_gain_meter uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [PW-1:0] glide(logic [PW-1:0] avg, logic [PW-1:0] s,
			logic fast);
		longint unsigned d, step;
		if (fast)
			return s;
		if (s >= avg) begin
			d = s - avg;
			step = (cur_alpha * d + 255) >> 8;
			return avg + step;
		end
		d = avg - s;
		step = (cur_alpha * d + 255) >> 8;
		return avg - step;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint log2_q16(longint unsigned x);
		int n;
		longint unsigned y, frac;
		n = 0;
		frac = 0;
		while (n < 63 && (x >> (n + 1)) != 0)
			n++;
		y = (n <= 30) ? x << (30 - n) : x >> (n - 30);
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			frac <<= 1;
			if (y >= (64'd2 << 30)) begin
				y >>= 1;
				frac |= 1;
			end
		end
		return longint'(n) * 65536 + longint'(frac);
	endfunction

	function automatic logic [15:0] swr_q8(logic [PW-1:0] f, logic [PW-1:0] r);
		longint unsigned q, rho, v;
		if (f == 0 || r >= f)
			return 16'hFFFF;
		q = (longint'(r) << 32) / f;
		rho = isqrt(q);
		if (rho > 65535)
			rho = 65535;
		v = ((65536 + rho) * 256) / (65536 - rho);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [10:0] gain_q4(logic [PW-1:0] o, logic [PW-1:0] i);
		longint d, p, g;
		longint unsigned mag;
		if (o == 0 && i == 0)
			return 11'd0;
		if (o == 0)
			return 11'h400;
		if (i == 0)
			return 11'h3FF;
		d = log2_q16(o) - log2_q16(i);
		p = d * longint'(rpsg_pkg::GAIN_K);
		mag = (p < 0) ? -p : p;
		mag = (mag + (64'd1 << 31)) >> 32;
		g = (p < 0) ? -longint'(mag) : longint'(mag);
		if (g > 1023)
			g = 1023;
		if (g < -1024)
			g = -1024;
		return g[10:0];
	endfunction

	function automatic meter_t meter_step(logic [PW-1:0] fin, logic [PW-1:0] fout,
			logic [PW-1:0] rout);
		meter_t r;
		logic fast;
		r = '0;
		if (cur_en && (fin != 0 || avg_in != 0 || avg_out != 0 || avg_rev != 0)) begin
			r.updated = 1'b1;
			fast = fin > avg_in;
			avg_in = glide(avg_in, fin, fast);
			if (avg_in < cur_in_floor)
				avg_in = '0;
			fast = fout > avg_out;
			avg_out = glide(avg_out, fout, fast);
			avg_rev = glide(avg_rev, rout, fast);
			if (avg_out < cur_out_floor)
				avg_out = '0;
			if (fout != 0)
				r.swr = swr_q8(avg_out, avg_rev);
			if (fin != 0 && fout != 0)
				r.gain = gain_q4(avg_out, avg_in);
		end
		r.in_avg = avg_in;
		r.out_avg = avg_out;
		r.rev_avg = avg_rev;
		return r;
	endfunction

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			rpsg_pkg::REG_ENABLED:      cur_en = val[0];
			rpsg_pkg::REG_DECAY_ALPHA:  cur_alpha = val[7:0];
			rpsg_pkg::REG_INPUT_FLOOR:  cur_in_floor = val[PW-1:0];
			rpsg_pkg::REG_OUTPUT_FLOOR: cur_out_floor = val[PW-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send(logic [PW-1:0] fin, logic [PW-1:0] fout, logic [PW-1:0] rout,
			logic typed, meter_t res);
		meter_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, rout, fout, fin};
		do @(posedge clk); while (!s_tready);
		r = meter_step(fin, fout, rout);
		pending_results.push_back(typed ? res : r);
	endtask

	task automatic stop_sending;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [PW-1:0] rand_power();
		logic [PW-1:0] v;
		v = PW'($urandom());
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return PMAX;
			2, 3:    return v >> $urandom_range(8, 19);
			4, 5, 6: return v >> $urandom_range(0, 12);
			default: return v;
		endcase
	endfunction

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= snk_stall);

	always @(posedge clk) begin
		meter_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[19:0], m_tdata[39:20], m_tdata[59:40],
				m_tdata[75:60], m_tdata[86:76]};
			if (pending_results.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected result %h", $time, got);
			end else begin
				want = pending_results.pop_front();
				if (got.updated !== want.updated)
					$display("%0t: updated exp %0d got %0d", $time, want.updated,
						got.updated);
				if (got.in_avg !== want.in_avg)
					$display("%0t: input_average exp %0d got %0d", $time, want.in_avg,
						got.in_avg);
				if (got.out_avg !== want.out_avg)
					$display("%0t: output_average exp %0d got %0d", $time, want.out_avg,
						got.out_avg);
				if (got.rev_avg !== want.rev_avg)
					$display("%0t: reverse_average exp %0d got %0d", $time, want.rev_avg,
						got.rev_avg);
				if (got.swr !== want.swr)
					$display("%0t: swr_ratio exp %0d got %0d", $time, want.swr, got.swr);
				if (got.gain !== want.gain)
					$display("%0t: gain_db exp %0d got %0d", $time,
						$signed(want.gain), $signed(got.gain));
				if (got !== want)
					n_fail++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("rf_power_swr_gain_meter_tb: FAIL");
			$finish;
		end
	end

	row_t dir_rows[$];
	phase_t phases[N_PHASE];

	initial begin
		meter_t none;
		logic [PW-1:0] a, b, c;
		none = '0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		src_idle = 0;
		snk_stall = 0;
		cur_en = 1'b0;
		cur_alpha = rpsg_pkg::ALPHA_RST;
		cur_in_floor = rpsg_pkg::IN_FLOOR_RST;
		cur_out_floor = rpsg_pkg::OUT_FLOOR_RST;
		avg_in = '0;
		avg_out = '0;
		avg_rev = '0;

		dir_rows = '{
			'{1'b0, PMAX, PMAX, PMAX, 1'b1, none},
			'{1'b1, 0, 0, 0, 1'b1, none},
			'{1'b1, 64, 0, 0, 1'b1, '{1'b1, 20'd64, 20'd0, 20'd0, 16'd0, 11'd0}},
			'{1'b1, 64, 1024, 2048, 1'b1,
				'{1'b1, 20'd64, 20'd1024, 20'd2048, 16'hFFFF, 11'd193}},
			'{1'b1, 64, 1024, 0, 1'b0, none},
			'{1'b1, 64, 1024, 10, 1'b0, none},
			'{1'b1, PMAX, PMAX, 0, 1'b0, none},
			'{1'b1, PMAX, PMAX, PMAX, 1'b0, none},
			'{1'b1, 1, PMAX, 1, 1'b0, none},
			'{1'b1, PMAX, 1, 0, 1'b0, none},
			'{1'b1, 5, 2000, 10, 1'b0, none},
			'{1'b1, 0, 0, 0, 1'b0, none},
			'{1'b1, 0, 3000, 100, 1'b0, none},
			'{1'b1, 100, 0, 0, 1'b0, none},
			'{1'b1, 1000, 10, 0, 1'b0, none},
			'{1'b1, 5, 5000, 20, 1'b0, none},
			'{1'b1, 20'h55555, 20'hAAAAA, 20'h55555, 1'b0, none},
			'{1'b1, 20'hAAAAA, 20'h55555, 20'hAAAAA, 1'b0, none},
			'{1'b1, 0, 0, 0, 1'b0, none}
		};
		phases = '{
			'{1'b1, 8'd51, 20'd6, 20'd64, 0, 0},
			'{1'b1, 8'd0, 20'd0, 20'd0, 57, 0},
			'{1'b1, 8'd255, PMAX, PMAX, 0, 57},
			'{1'b1, 8'd200, 20'd100, 20'd1000, 24, 24},
			'{1'b0, 8'd128, 20'd6, 20'd64, 57, 57},
			'{1'b1, 8'd13, 20'd20, 20'd300, 0, 0}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].en != cur_en) begin
				stop_sending();
				drain();
				reg_write(rpsg_pkg::REG_ENABLED, {31'd0, dir_rows[i].en});
			end
			send(dir_rows[i].fwd_in, dir_rows[i].fwd_out, dir_rows[i].rev_out,
				dir_rows[i].typed, dir_rows[i].res);
		end

		foreach (phases[p]) begin
			stop_sending();
			drain();
			reg_write(rpsg_pkg::REG_ENABLED, {31'd0, phases[p].en});
			reg_write(rpsg_pkg::REG_DECAY_ALPHA, {24'd0, phases[p].alpha});
			reg_write(rpsg_pkg::REG_INPUT_FLOOR, {12'd0, phases[p].in_floor});
			reg_write(rpsg_pkg::REG_OUTPUT_FLOOR, {12'd0, phases[p].out_floor});
			src_idle = phases[p].src_idle;
			snk_stall = phases[p].snk_stall;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 70) begin
					// plausible amplifier: output above drive, reflection below output
					a = rand_power();
					b = a + PW'($urandom() >> $urandom_range(4, 19));
					if (b < a)
						b = PMAX;
					c = b >> $urandom_range(0, 12);
				end else begin
					a = rand_power();
					b = rand_power();
					c = rand_power();
				end
				send(a, b, c, 1'b0, none);
			end
		end
		stop_sending();
		snk_stall = 0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (n_fail == 0)
			$display("rf_power_swr_gain_meter_tb: PASS");
		else
			$display("rf_power_swr_gain_meter_tb: FAIL");
		$finish;
	end

endmodule
